FILE: rtl/core/rflr_pkg.sv
`default_nettype none
package rflr_pkg;

	localparam int CODE_W = 20;
	localparam int FRAME_W = 24;
	localparam int COUNT_W = 8;
	localparam int LEARNED_MAX_DEF = 128;

	localparam logic [CODE_W-1:0] CODE_ONES = {CODE_W{1'b1}};

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NONE    = 2'd0;
	localparam kind_t KIND_LEARNED = 2'd1;
	localparam kind_t KIND_EMERG   = 2'd2;
	localparam kind_t KIND_ALARM   = 2'd3;

	typedef logic [1:0] target_t;
	localparam target_t TGT_USER  = 2'd0;
	localparam target_t TGT_ALARM = 2'd1;

	typedef struct packed {
		logic               req_type;
		logic [FRAME_W-1:0] frame_bits;
		logic               format_alt;
		logic               learn_menu;
		target_t            learn_target;
		logic               master_present;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         relay_mask;
		kind_t              match_kind;
		logic               code_learned;
		logic               table_full;
		logic [COUNT_W-1:0] learned_count_out;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
		logic emit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
	} status_t;

	function automatic logic slot_empty(input logic [CODE_W-1:0] v);
		return (v == '0) || (v == CODE_ONES);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rflr_if.sv
`default_nettype none
interface rflr_in_if;
	logic                valid;
	logic                ready;
	rflr_pkg::in_item_t  payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface rflr_out_if;
	logic                valid;
	logic                ready;
	rflr_pkg::out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rflr_ram.sv
`default_nettype none
module rflr_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rflr_datapath.sv
`default_nettype none
module rflr_datapath #(
	parameter int LEARNED_MAX = rflr_pkg::LEARNED_MAX_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rflr_pkg::in_item_t  in_item,
	input  wire rflr_pkg::cmd_t      cmd,
	output rflr_pkg::status_t        status,
	output rflr_pkg::out_item_t      out_item
);

	localparam int AW = (LEARNED_MAX > 1) ? $clog2(LEARNED_MAX) : 1;
	localparam logic [rflr_pkg::COUNT_W-1:0] MAX_CNT = rflr_pkg::COUNT_W'(LEARNED_MAX);

	// Persistent state.
	logic [rflr_pkg::CODE_W-1:0]  emerg_q, alarm_q;
	logic [rflr_pkg::COUNT_W-1:0] count_q;
	logic                         hold_q;
	logic [3:0]                   relays_q;

	// Per-transaction registers.
	logic                         release_q, learn_q, master_q;
	rflr_pkg::target_t            target_q;
	logic [rflr_pkg::CODE_W-1:0]  code_q;
	logic [3:0]                   toggle_q;
	rflr_pkg::kind_t              kind_q;
	logic [rflr_pkg::COUNT_W-1:0] addr_q;
	logic                         pend_s1;
	logic                         res_learned_q, res_full_q;

	logic [rflr_pkg::CODE_W-1:0]  in_code;
	logic [3:0]                   in_toggle;
	rflr_pkg::kind_t              in_kind;
	logic [rflr_pkg::CODE_W-1:0]  rdata;
	logic                         issue, hit, ram_we, do_learn, do_toggle;
	logic                         list_full;

	// Frame unpacking; a button is pressed when its bit is low.
	always_comb begin
		if (in_item.format_alt) begin
			in_code   = in_item.frame_bits[23:4];
			in_toggle = {~in_item.frame_bits[1], ~in_item.frame_bits[3],
				~in_item.frame_bits[0], ~in_item.frame_bits[2]};
		end else begin
			in_code   = {in_item.frame_bits[23:8], 4'b0000};
			in_toggle = {~in_item.frame_bits[5], ~in_item.frame_bits[3],
				~in_item.frame_bits[7], ~in_item.frame_bits[1]};
		end
		priority if (!rflr_pkg::slot_empty(emerg_q) && emerg_q == in_code) begin
			in_kind = rflr_pkg::KIND_EMERG;
		end else if (!rflr_pkg::slot_empty(alarm_q) && alarm_q == in_code) begin
			in_kind = rflr_pkg::KIND_ALARM;
		end else begin
			in_kind = rflr_pkg::KIND_NONE;
		end
	end

	assign issue = cmd.scan && (addr_q < count_q);
	assign hit   = cmd.scan && pend_s1 && (rdata == code_q);
	assign status.scan_done = release_q || (kind_q != rflr_pkg::KIND_NONE) ||
		(!pend_s1 && (addr_q >= count_q));

	assign list_full = (count_q >= MAX_CNT);
	assign do_learn  = !release_q && learn_q && (kind_q == rflr_pkg::KIND_NONE);
	assign ram_we    = cmd.apply && do_learn && master_q &&
		(target_q == rflr_pkg::TGT_USER) && !list_full;
	assign do_toggle = !release_q && !learn_q && (kind_q != rflr_pkg::KIND_NONE) && !hold_q;

	rflr_ram #(
		.WIDTH(rflr_pkg::CODE_W),
		.DEPTH(LEARNED_MAX)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(code_q),
		.re   (issue),
		.raddr(addr_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emerg_q  <= rflr_pkg::CODE_ONES;
			alarm_q  <= rflr_pkg::CODE_ONES;
			count_q  <= '0;
			hold_q   <= 1'b0;
			relays_q <= '0;
		end else if (cmd.apply) begin
			if (release_q) begin
				hold_q <= 1'b0;
			end else if (do_learn) begin
				priority if (!master_q) begin
					emerg_q <= code_q;
				end else if (target_q == rflr_pkg::TGT_USER) begin
					if (!list_full) begin
						count_q <= count_q + 1'b1;
					end
				end else if (target_q == rflr_pkg::TGT_ALARM) begin
					alarm_q <= code_q;
				end else begin
				end
			end else if (do_toggle) begin
				hold_q   <= 1'b1;
				relays_q <= relays_q ^ toggle_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			release_q <= in_item.req_type;
			learn_q   <= in_item.learn_menu;
			master_q  <= in_item.master_present;
			target_q  <= in_item.learn_target;
			code_q    <= in_code;
			toggle_q  <= in_toggle;
			kind_q    <= in_item.req_type ? rflr_pkg::KIND_NONE : in_kind;
			addr_q    <= '0;
			pend_s1   <= 1'b0;
		end else if (cmd.scan) begin
			pend_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (hit) begin
				kind_q <= rflr_pkg::KIND_LEARNED;
			end
		end
		if (cmd.apply) begin
			res_learned_q <= do_learn && (!master_q ||
				(target_q == rflr_pkg::TGT_USER && !list_full) ||
				target_q == rflr_pkg::TGT_ALARM);
			res_full_q <= do_learn && master_q &&
				(target_q == rflr_pkg::TGT_USER) && list_full;
		end
		if (cmd.emit) begin
			out_item.relay_mask        <= relays_q;
			out_item.match_kind        <= kind_q;
			out_item.code_learned      <= res_learned_q;
			out_item.table_full        <= res_full_q;
			out_item.learned_count_out <= count_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rflr_ctrl.sv
`default_nettype none
module rflr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire rflr_pkg::status_t status,
	output rflr_pkg::cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.scan  = (state_q == S_SCAN) && !status.scan_done;
		cmd.apply = (state_q == S_APPLY);
		cmd.emit  = (state_q == S_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (status.scan_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rf_remote_learn_and_relay_toggle_top.sv
// A release event or a special-slot hit gives its result without a scan of the
// learned list; any other code scans the learned list first.
// Throughput: one transaction at a time; the scan reads one learned code per
// cycle from the two-port code memory, so the rate follows the list length.
// A result waiting in the output register does not stop the next input.
// Reset: asynchronous, clears relays, hold, count and empties the special slots.
`default_nettype none
module rf_remote_learn_and_relay_toggle_top #(
	parameter int LEARNED_MAX = rflr_pkg::LEARNED_MAX_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rflr_in_if.sink     in_ch,
	rflr_out_if.source  out_ch
);

	rflr_pkg::cmd_t    cmd;
	rflr_pkg::status_t status;

	rflr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rflr_datapath #(
		.LEARNED_MAX(LEARNED_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_ch.payload),
		.cmd     (cmd),
		.status  (status),
		.out_item(out_ch.payload)
	);

endmodule
`default_nettype wire

FILE: rtl/core/rflr_checker.sv
`default_nettype none
module rflr_checker #(
	parameter int LEARNED_MAX = rflr_pkg::LEARNED_MAX_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire rflr_pkg::out_item_t out_item
);

	// A held result must not change until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// One transaction in flight: no input is taken in the cycle after one.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.learned_count_out <= rflr_pkg::COUNT_W'(LEARNED_MAX))
		else $error("learned count beyond limit");

	a_learn_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.code_learned && out_item.table_full))
		else $error("learned and full together");

	// Only an unmatched code is ever stored.
	a_learn_unmatched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.code_learned |-> out_item.match_kind == rflr_pkg::KIND_NONE)
		else $error("matched code stored");

endmodule

bind rf_remote_learn_and_relay_toggle_top rflr_checker #(
	.LEARNED_MAX(LEARNED_MAX)
) u_rflr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_item (out_ch.payload)
);
`default_nettype wire
